/* design/hms_pkg.sv */
// Shared types for the Hill-type muscle step block: sequencer states,
// arithmetic unit opcodes, register indexes and the control/status structs.
// No dependencies.
package hms_pkg;

  typedef enum logic [2:0] {
    CFG_OPT_FIBER   = 3'd0,
    CFG_SLACK       = 3'd1,
    CFG_PEAK_FORCE  = 3'd2,
    CFG_ACT_RATE    = 3'd3,
    CFG_STEP_LENGTH = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_ABS,
    OP_MUL,
    OP_DIV,
    OP_LERP
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_ctl_t;

  typedef struct packed {
    logic done;
    logic sat;
  } alu_sts_t;

  typedef enum logic [5:0] {
    S_IDLE,
    S_INIT,
    S_BLEND,
    S_ONE_M,
    S_KEEP,
    S_DRIVE,
    S_ACT,
    S_DISP,
    S_LEN,
    S_TENDON,
    S_TDIV,
    S_STRETCH,
    S_FSE_LIN,
    S_FSE,
    S_REL,
    S_DEV,
    S_SPREAD,
    S_LO_ARG,
    S_LO_LIN,
    S_LO_SQ,
    S_HI_SQ,
    S_FPE,
    S_FCE,
    S_ABS,
    S_SQ,
    S_CUBE,
    S_LIDX,
    S_LRD,
    S_LERP,
    S_DEN,
    S_VF,
    S_BRANCH,
    S_C_ARG,
    S_C_NUM,
    S_C_DLIN,
    S_C_DEN,
    S_C_DIV,
    S_C_NEG,
    S_E_ARG,
    S_E_ECC,
    S_E_NUM0,
    S_E_NUM,
    S_E_DLIN,
    S_E_DEN,
    S_E_DIV,
    S_VEL,
    S_FORCE,
    S_DONE
  } seq_state_t;

endpackage

/* design/hms_alu.sv */
// Shared saturating arithmetic unit: add, subtract, abs, fixed-point multiply,
// table interpolation and restoring divide (one bit per cycle).
// Depends on hms_pkg.
module hms_alu import hms_pkg::*; #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  alu_ctl_t            ctl,
  input  logic signed [W-1:0] a,
  input  logic signed [W-1:0] b,
  input  logic [F+1:0]        part,
  output logic signed [W-1:0] res,
  output alu_sts_t            sts
);

  localparam int PW = (W > F + 2) ? W : F + 2;
  localparam int CW = $clog2(W + 2);
  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  logic [W-1:0]      ma, mb;
  logic              neg;
  logic [W:0]        sum;
  logic              as_ovf;
  logic signed [W-1:0] as_res;
  logic [W-1:0]      mx;
  logic [PW-1:0]     my;
  logic [W+PW-1:0]   prod, q;
  logic [W:0]        lim;
  logic              mul_ovf;
  logic signed [W-1:0] mul_res, lerp_res;
  logic [W+F-1:0]    sh;
  logic [W-1:0]      dhi;
  logic              d_ovf;

  logic              busy, dneg;
  logic [CW-1:0]     cnt;
  logic [W-1:0]      rem, ub;
  logic [W:0]        dvd, quo, r2, lim_d;
  logic              ge;

  assign ma  = a[W-1] ? (~a + 1'b1) : a;
  assign mb  = b[W-1] ? (~b + 1'b1) : b;
  assign neg = a[W-1] ^ b[W-1];

  always_comb begin
    unique case (ctl.op)
      OP_ADD:  sum = {a[W-1], a} + {b[W-1], b};
      OP_ABS:  sum = {(W+1){1'b0}} - {a[W-1], a};
      default: sum = {a[W-1], a} - {b[W-1], b};
    endcase
  end

  assign as_ovf = sum[W] != sum[W-1];
  assign as_res = as_ovf ? (sum[W] ? WMIN : WMAX) : sum[W-1:0];

  // one multiplier serves both the product and the interpolation step
  assign mx   = (ctl.op == OP_LERP) ? W'(a - b) : ma;
  assign my   = (ctl.op == OP_LERP) ? PW'(part) : PW'(mb);
  assign prod = mx * my;
  assign q    = prod >> F;
  assign lim  = (W+1)'(WMAX) + (W+1)'(neg);
  assign mul_ovf  = q > (W+PW)'(lim);
  assign mul_res  = mul_ovf ? (neg ? WMIN : WMAX) : (neg ? -q[W-1:0] : q[W-1:0]);
  assign lerp_res = a - W'(prod >> (F + 2));

  // quotient bits above the W+1 we develop must be zero
  assign sh    = {ma, {F{1'b0}}};
  assign dhi   = W'(sh >> (W + 1));
  assign d_ovf = dhi >= mb;

  assign r2    = {rem, dvd[W]};
  assign ge    = r2 >= {1'b0, ub};
  assign lim_d = (W+1)'(WMAX) + (W+1)'(dneg);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      sts  <= '0;
    end else begin
      sts <= '0;
      if (ctl.start) begin
        unique case (ctl.op)
          OP_ADD, OP_SUB: begin
            res <= as_res;
            sts <= '{done: 1'b1, sat: as_ovf};
          end
          OP_ABS: begin
            res <= a[W-1] ? as_res : a;
            sts <= '{done: 1'b1, sat: as_ovf};
          end
          OP_MUL: begin
            res <= mul_res;
            sts <= '{done: 1'b1, sat: mul_ovf};
          end
          OP_LERP: begin
            res <= lerp_res;
            sts <= '{done: 1'b1, sat: 1'b0};
          end
          OP_DIV: begin
            if (b == '0) begin
              res <= (a == '0) ? '0 : (a[W-1] ? WMIN : WMAX);
              sts <= '{done: 1'b1, sat: 1'b1};
            end else if (d_ovf) begin
              res <= neg ? WMIN : WMAX;
              sts <= '{done: 1'b1, sat: 1'b1};
            end else begin
              busy <= 1'b1;
              cnt  <= CW'(W + 1);
              rem  <= dhi;
              dvd  <= sh[W:0];
              quo  <= '0;
              ub   <= mb;
              dneg <= neg;
            end
          end
          default: begin
            res <= '0;
          end
        endcase
      end else if (busy) begin
        if (cnt != '0) begin
          rem <= ge ? W'(r2 - {1'b0, ub}) : r2[W-1:0];
          dvd <= {dvd[W-1:0], 1'b0};
          quo <= {quo[W-1:0], ge};
          cnt <= cnt - 1'b1;
        end else begin
          busy <= 1'b0;
          if (quo > lim_d) begin
            res <= dneg ? WMIN : WMAX;
            sts <= '{done: 1'b1, sat: 1'b1};
          end else begin
            res <= dneg ? -quo[W-1:0] : quo[W-1:0];
            sts <= '{done: 1'b1, sat: 1'b0};
          end
        end
      end
    end
  end

endmodule

/* design/hill_muscle_step.sv */
// Top level of the Hill-type muscle step: sequencer, state registers,
// force-length table and output register. Depends on hms_pkg and hms_alu.
//
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------------------
//  s_      | s_tvalid/s_tready  | s_tuser: kind; s_tdata: excitation, path_length
//  m_      | m_tvalid/m_tready  | m_tdata: force_res, activation_out,
//          |                    |          fiber_length_out, saturated
//  cfg_    | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A step request runs 31 (concentric) or 32 (eccentric) single ops and 4
// divides through the shared unit; a divide by zero or an overflowing
// divide ends without the bit-serial loop. An init request runs a single
// subtract. s_tready is high only in idle; the result waits in the output
// register while the next request is accepted, and a result still held there
// stalls the next one in S_DONE. Reset is synchronous and restores the
// sequencer, the output valid, the configuration registers, act, fl and vel.
module hill_muscle_step import hms_pkg::*; #(
  parameter int DATA_WIDTH      = 32,
  parameter int FRAC_BITS       = 16,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // excitation[16:0], path_length[47:17]
  input  logic [0:0]  s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // force_res[31:0], activation_out[48:32],
                                 // fiber_length_out[80:49], saturated[81]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int DB = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int SW = F + 2 + DB;

  localparam longint WMAX_L = (longint'(1) <<< (W - 1)) - 1;
  localparam longint FOUR_L = longint'(1) << (F + 2);
  localparam logic signed [W-1:0] WMAX    = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] ONE     = W'(longint'(1) << F);
  localparam logic signed [W-1:0] TWO     = W'(longint'(2) << F);
  localparam logic signed [W-1:0] FIVE    = W'(longint'(5) << F);
  localparam logic signed [W-1:0] TEN     = W'(longint'(10) << F);
  localparam logic signed [W-1:0] K25     = W'(longint'(25) << F);
  localparam logic signed [W-1:0] MIN_ACT = W'(((longint'(1) << F) + 5000) / 10000);
  localparam logic signed [W-1:0] OMEGA   = W'(((longint'(25) << F) + 7) / 14);
  localparam logic signed [W-1:0] OMEGA2  = W'(2 * (((longint'(25) << F) + 7) / 14));
  localparam logic signed [W-1:0] C044    = W'(((longint'(44) << F) + 50) / 100);
  localparam logic signed [W-1:0] K378    = W'(((longint'(378) << F) + 5) / 10);
  localparam logic signed [W-1:0] FV_TOP  = W'(longint'(3) << (F - 1));
  localparam longint unsigned NEG_LN_C_Q32 = 64'd12866572143;

  typedef logic [W-1:0] ftab_t [EXP_TABLE_DEPTH+1];

  // 0.05^(4n/depth): series in Q30, eight squarings, rounded to F bits
  function automatic ftab_t build_fl_tab();
    ftab_t tab;
    longint unsigned y, z, z2, z3, z4, e;
    int s;
    s = 30 - F;
    for (int n = 0; n <= EXP_TABLE_DEPTH; n++) begin
      y  = (NEG_LN_C_Q32 * 64'd4 * longint'(n)) / EXP_TABLE_DEPTH;
      z  = y >> 10;
      z2 = (z * z) >> 30;
      z3 = (z2 * z) >> 30;
      z4 = (z3 * z) >> 30;
      e  = (64'd1 << 30) - z + z2 / 2 - z3 / 6 + z4 / 24;
      for (int k = 0; k < 8; k++) e = (e * e + (64'd1 << 29)) >> 30;
      if (s > 0) e = (e + (64'd1 << (s > 0 ? s - 1 : 0))) >> s;
      tab[n] = W'(e);
    end
    return tab;
  endfunction

  localparam ftab_t FL_TAB = build_fl_tab();

  function automatic logic [W:0] clamp_u31(logic [30:0] x);
    longint v;
    v = longint'({33'd0, x});
    if (v > WMAX_L) return {1'b1, WMAX};
    return {1'b0, W'(v)};
  endfunction

  function automatic logic [32:0] sat32(logic signed [W-1:0] x);
    longint v;
    v = longint'(x);
    if (v > 64'sd2147483647) return {1'b1, 32'h7fff_ffff};
    if (v < -64'sd2147483648) return {1'b1, 32'h8000_0000};
    return {1'b0, v[31:0]};
  endfunction

  // configuration registers
  logic [30:0] reg_opt, reg_slack, reg_peak, reg_rate;
  logic [16:0] reg_step;

  logic [W:0]  opt_c, slack_c, peak_c, rate_c, path_c;
  logic signed [W-1:0] opt_w, slack_w, peak_w, rate_w, dt_w;
  logic        in_sat;

  seq_state_t  state, state_next;
  logic        issued;
  logic        uses_alu;
  alu_ctl_t    alu_ctl;
  alu_sts_t    alu_sts;
  alu_op_t     op;
  logic signed [W-1:0] opa, opb, alu_res;

  logic signed [W-1:0] act, fl, vel;
  logic signed [W-1:0] t0, t1, fse, rel, spread, fce, vf, force_r;
  logic signed [W-1:0] path_w, exc_w, spread_pos, res_pos, cube_c;
  logic        kind_r, sat_acc;
  logic [DB-1:0] idx_a, idx_b;
  logic [F+1:0]  lpart;
  logic [SW-1:0] scaled;
  logic [W-1:0]  tab_hi, tab_lo;
  logic [32:0]   force_o, fl_o;
  logic          adv;

  assign opt_c   = clamp_u31(reg_opt);
  assign slack_c = clamp_u31(reg_slack);
  assign peak_c  = clamp_u31(reg_peak);
  assign rate_c  = clamp_u31(reg_rate);
  assign path_c  = clamp_u31(s_tdata[47:17]);
  assign opt_w   = opt_c[W-1:0];
  assign slack_w = slack_c[W-1:0];
  assign peak_w  = peak_c[W-1:0];
  assign rate_w  = rate_c[W-1:0];
  assign dt_w    = W'(reg_step);
  assign in_sat  = opt_c[W] | slack_c[W] | peak_c[W] | rate_c[W] | path_c[W];

  assign cfg_ready  = !rst;
  assign spread_pos = spread[W-1] ? '0 : spread;
  assign res_pos    = alu_res[W-1] ? '0 : alu_res;
  assign cube_c     = t1[W-1] ? '0 : t1;
  assign scaled     = SW'(cube_c[F+1:0]) * SW'(EXP_TABLE_DEPTH);
  assign force_o    = sat32(force_r);
  assign fl_o       = sat32(fl);
  assign adv        = alu_sts.done;

  hms_alu #(.W(W), .F(F)) u_alu (
    .clk  (clk),
    .rst  (rst),
    .ctl  (alu_ctl),
    .a    (opa),
    .b    (opb),
    .part (lpart),
    .res  (alu_res),
    .sts  (alu_sts)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (s_tvalid) state_next = s_tuser[0] ? S_INIT : S_BLEND;
      S_INIT:    if (adv) state_next = S_DONE;
      S_BLEND:   if (adv) state_next = S_ONE_M;
      S_ONE_M:   if (adv) state_next = S_KEEP;
      S_KEEP:    if (adv) state_next = S_DRIVE;
      S_DRIVE:   if (adv) state_next = S_ACT;
      S_ACT:     if (adv) state_next = S_DISP;
      S_DISP:    if (adv) state_next = S_LEN;
      S_LEN:     if (adv) state_next = S_TENDON;
      S_TENDON:  if (adv) state_next = S_TDIV;
      S_TDIV:    if (adv) state_next = S_STRETCH;
      S_STRETCH: if (adv) state_next = S_FSE_LIN;
      S_FSE_LIN: if (adv) state_next = S_FSE;
      S_FSE:     if (adv) state_next = S_REL;
      S_REL:     if (adv) state_next = S_DEV;
      S_DEV:     if (adv) state_next = S_SPREAD;
      S_SPREAD:  if (adv) state_next = S_LO_ARG;
      S_LO_ARG:  if (adv) state_next = S_LO_LIN;
      S_LO_LIN:  if (adv) state_next = S_LO_SQ;
      S_LO_SQ:   if (adv) state_next = S_HI_SQ;
      S_HI_SQ:   if (adv) state_next = S_FPE;
      S_FPE:     if (adv) state_next = S_FCE;
      S_FCE:     if (adv) state_next = S_ABS;
      S_ABS:     if (adv) state_next = S_SQ;
      S_SQ:      if (adv) state_next = S_CUBE;
      S_CUBE:    if (adv) state_next = S_LIDX;
      S_LIDX:    state_next = S_LRD;
      S_LRD:     state_next = S_LERP;
      S_LERP:    if (adv) state_next = S_DEN;
      S_DEN:     if (adv) state_next = S_VF;
      S_VF:      if (adv) state_next = S_BRANCH;
      S_BRANCH:  state_next = (vf < ONE) ? S_C_ARG : S_E_ARG;
      S_C_ARG:   if (adv) state_next = S_C_NUM;
      S_C_NUM:   if (adv) state_next = S_C_DLIN;
      S_C_DLIN:  if (adv) state_next = S_C_DEN;
      S_C_DEN:   if (adv) state_next = S_C_DIV;
      S_C_DIV:   if (adv) state_next = S_C_NEG;
      S_C_NEG:   if (adv) state_next = S_VEL;
      S_E_ARG:   if (adv) state_next = S_E_ECC;
      S_E_ECC:   if (adv) state_next = S_E_NUM0;
      S_E_NUM0:  if (adv) state_next = S_E_NUM;
      S_E_NUM:   if (adv) state_next = S_E_DLIN;
      S_E_DLIN:  if (adv) state_next = S_E_DEN;
      S_E_DEN:   if (adv) state_next = S_E_DIV;
      S_E_DIV:   if (adv) state_next = S_VEL;
      S_VEL:     if (adv) state_next = S_FORCE;
      S_FORCE:   if (adv) state_next = S_DONE;
      S_DONE:    if (!m_tvalid || m_tready) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // operand selection for the shared unit
  always_comb begin
    uses_alu = 1'b1;
    op  = OP_MUL;
    opa = t0;
    opb = t1;
    unique case (state)
      S_IDLE, S_LIDX, S_LRD, S_BRANCH, S_DONE: uses_alu = 1'b0;
      S_INIT:    begin op = OP_SUB; opa = path_w;  opb = slack_w; end
      S_BLEND:   begin opa = dt_w;  opb = rate_w; end
      S_ONE_M:   begin op = OP_SUB; opa = ONE; opb = t0; end
      S_KEEP:    begin opa = t1; opb = act; end
      S_DRIVE:   begin opa = t0; opb = exc_w; end
      S_ACT:     begin op = OP_ADD; opa = t1; opb = t0; end
      S_DISP:    begin opa = dt_w; opb = vel; end
      S_LEN:     begin op = OP_ADD; opa = fl; opb = t0; end
      S_TENDON:  begin op = OP_SUB; opa = path_w; opb = fl; end
      S_TDIV:    begin op = OP_DIV; opa = t0; opb = slack_w; end
      S_STRETCH: begin op = OP_SUB; opa = t0; opb = ONE; end
      S_FSE_LIN: begin opa = t0; opb = K25; end
      S_FSE:     begin opa = t0; opb = t0; end
      S_REL:     begin op = OP_DIV; opa = fl; opb = opt_w; end
      S_DEV:     begin op = OP_SUB; opa = rel; opb = ONE; end
      S_SPREAD:  begin opa = OMEGA; opb = t0; end
      S_LO_ARG:  begin op = OP_SUB; opa = C044; opb = rel; end
      S_LO_LIN:  begin opa = OMEGA2; opb = t1; end
      S_LO_SQ:   begin opa = t1; opb = t1; end
      S_HI_SQ:   begin opa = spread_pos; opb = spread_pos; end
      S_FPE:     begin op = OP_SUB; opa = t0; opb = t1; end
      S_FCE:     begin op = OP_SUB; opa = fse; opb = t0; end
      S_ABS:     begin op = OP_ABS; opa = spread; opb = '0; end
      S_SQ:      begin opa = t0; opb = t0; end
      S_CUBE:    begin opa = t1; opb = t0; end
      S_LERP:    begin op = OP_LERP; opa = tab_hi; opb = tab_lo; end
      S_DEN:     begin opa = act; opb = t0; end
      S_VF:      begin op = OP_DIV; opa = fce; opb = t0; end
      S_C_ARG:   begin op = OP_SUB; opa = ONE; opb = vf; end
      S_C_NUM:   begin opa = TEN; opb = t0; end
      S_C_DLIN:  begin opa = FIVE; opb = vf; end
      S_C_DEN:   begin op = OP_ADD; opa = t1; opb = ONE; end
      S_C_DIV:   begin op = OP_DIV; opa = t0; opb = t1; end
      S_C_NEG:   begin op = OP_SUB; opa = '0; opb = t0; end
      S_E_ARG:   begin op = OP_SUB; opa = vf; opb = FV_TOP; end
      S_E_ECC:   begin opa = TWO; opb = t0; end
      S_E_NUM0:  begin op = OP_ADD; opa = t0; opb = ONE; end
      S_E_NUM:   begin opa = TEN; opb = t1; end
      S_E_DLIN:  begin opa = K378; opb = t0; end
      S_E_DEN:   begin op = OP_SUB; opa = ONE; opb = t0; end
      S_E_DIV:   begin op = OP_DIV; opa = t1; opb = t0; end
      S_VEL:     begin opa = t0; opb = opt_w; end
      S_FORCE:   begin opa = fse; opb = peak_w; end
      default:   uses_alu = 1'b0;
    endcase
    alu_ctl  = '{start: uses_alu && !issued, op: op};
    s_tready = (state == S_IDLE) && !rst;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issued    <= 1'b0;
      m_tvalid  <= 1'b0;
      reg_opt   <= 31'd6554;
      reg_slack <= 31'd6554;
      reg_peak  <= 31'd0;
      reg_rate  <= 31'd6553600;
      reg_step  <= 17'd66;
      act       <= MIN_ACT;
      fl        <= W'(6554);
      vel       <= '0;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_OPT_FIBER:   reg_opt   <= cfg_data;
          CFG_SLACK:       reg_slack <= cfg_data;
          CFG_PEAK_FORCE:  reg_peak  <= cfg_data;
          CFG_ACT_RATE:    reg_rate  <= cfg_data;
          CFG_STEP_LENGTH: reg_step  <= cfg_data[16:0];
          default: ;
        endcase
      end

      if (alu_ctl.start) issued <= 1'b1;
      if (alu_sts.done) begin
        issued  <= 1'b0;
        sat_acc <= sat_acc | alu_sts.sat;
      end

      // S_DONE reloads the output register itself
      if (m_tvalid && m_tready && state != S_DONE) m_tvalid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            kind_r  <= s_tuser[0];
            path_w  <= path_c[W-1:0];
            exc_w   <= W'(s_tdata[16:0]);
            sat_acc <= in_sat;
            force_r <= '0;
          end
        end
        S_INIT:    if (adv) fl <= res_pos;
        S_BLEND, S_DRIVE, S_DISP, S_TENDON, S_TDIV, S_STRETCH, S_DEV, S_HI_SQ,
        S_FPE, S_ABS, S_LERP, S_DEN, S_C_ARG, S_C_NUM, S_C_DIV, S_C_NEG,
        S_E_ARG, S_E_ECC, S_E_DLIN, S_E_DEN, S_E_DIV: begin
          if (adv) t0 <= alu_res;
        end
        S_ONE_M, S_KEEP, S_LO_ARG, S_LO_SQ, S_SQ, S_CUBE, S_C_DLIN, S_C_DEN,
        S_E_NUM0, S_E_NUM: begin
          if (adv) t1 <= alu_res;
        end
        S_ACT: begin
          if (adv) begin
            if (alu_res < MIN_ACT) act <= MIN_ACT;
            else if (alu_res > ONE) act <= ONE;
            else act <= alu_res;
          end
        end
        S_LEN:     if (adv) fl <= alu_res;
        S_FSE_LIN: if (adv) t0 <= res_pos;
        S_FSE:     if (adv) fse <= alu_res;
        S_REL:     if (adv) rel <= alu_res;
        S_SPREAD:  if (adv) spread <= alu_res;
        S_LO_LIN:  if (adv) t1 <= res_pos;
        S_FCE:     if (adv) fce <= alu_res;
        S_LIDX: begin
          // argument of four or more sits on the last entry
          if (longint'(cube_c) >= FOUR_L) begin
            idx_a <= DB'(EXP_TABLE_DEPTH);
            idx_b <= DB'(EXP_TABLE_DEPTH);
            lpart <= '0;
          end else begin
            idx_a <= DB'(scaled >> (F + 2));
            idx_b <= DB'(scaled >> (F + 2)) + 1'b1;
            lpart <= scaled[F+1:0];
          end
        end
        S_LRD: begin
          tab_hi <= FL_TAB[idx_a];
          tab_lo <= FL_TAB[idx_b];
        end
        S_VF: begin
          if (adv) begin
            if (alu_res[W-1]) vf <= '0;
            else if (alu_res > FV_TOP) vf <= FV_TOP;
            else vf <= alu_res;
          end
        end
        S_BRANCH: ;
        S_VEL:     if (adv) vel <= alu_res;
        S_FORCE:   if (adv) force_r <= alu_res;
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {6'd0, (kind_r ? 1'b0 : sat_acc) | force_o[32] | fl_o[32],
                         fl_o[31:0], act[16:0], force_o[31:0]};
          end
        end
        default: ;
      endcase
    end
  end

  a_act_range: assert property (@(posedge clk) disable iff (rst)
    act >= MIN_ACT && act <= ONE)
    else $error("activation left its clamp range");

  a_vf_range: assert property (@(posedge clk) disable iff (rst)
    state == S_BRANCH |-> !vf[W-1] && vf <= FV_TOP)
    else $error("force-velocity factor out of range");

  a_done_issued: assert property (@(posedge clk) disable iff (rst)
    alu_sts.done |-> issued)
    else $error("arithmetic unit finished without an issued op");

  a_tab_index: assert property (@(posedge clk) disable iff (rst)
    state == S_LERP |-> (idx_b == idx_a) || (idx_b == idx_a + 1'b1))
    else $error("table neighbor index mismatch");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken again while a request is in work");

endmodule
